/* hdl/tone_burst_detector_unit_defines.svh */
// Assertion macros for the tone burst detector.
`ifndef TONE_BURST_DETECTOR_UNIT_DEFINES_SVH
`define TONE_BURST_DETECTOR_UNIT_DEFINES_SVH

// Same-cycle implication.
`define TBD_ASSERT_IMPLY(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("tone burst detector: same-cycle check failed");

// Next-cycle implication.
`define TBD_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("tone burst detector: next-cycle check failed");

`endif

/* hdl/tbd_pkg.sv */
`default_nettype none

package tbd_pkg;

  localparam int WINDOW_DEF = 10;

  localparam int SAMPLE_W   = 10;
  localparam int TIME_W     = 32;
  localparam int OFFSET_W   = 10;
  localparam int HOLD_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // mean is at most 1023, so 10 quotient bits suffice
  localparam int MEAN_W = 10;

  localparam logic [OFFSET_W-1:0] SPIKE_OFFSET_RST = 10'd60;
  localparam logic [HOLD_W-1:0]   HOLD_MS_RST      = 16'd1000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SPIKE_OFFSET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS      = 1'b1;

  typedef struct packed {
    logic                en;
    logic [SAMPLE_W-1:0] data;
  } ring_wr_t;

endpackage

`default_nettype wire

/* hdl/tone_burst_detector_unit.sv */
// While the ring is filling, an input beat passes from S_IDLE straight to S_FINISH and the
// output register; once it is full, the serial ring sum and reciprocal multiply in tbd_mean come between.
// Beats are taken one at a time: in_stall holds off the next beat until S_FINISH is done.
// A new beat is taken while the previous result still waits in the output register.
// Reset (synchronous, active high) clears the sequencer, fill count, write slot,
// spike state and restores spike_offset = 60, hold_ms = 1000; ring contents are kept.
`default_nettype none

module tone_burst_detector_unit #(
  parameter int WINDOW = tbd_pkg::WINDOW_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // input beats
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [tbd_pkg::SAMPLE_W-1:0]   sample,
  input  wire logic [tbd_pkg::TIME_W-1:0]     now_ms,
  // result beats
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                go,
  output logic                                above,
  output logic      [tbd_pkg::MEAN_W-1:0]     baseline,
  // register writes
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tbd_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW    = $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_MEAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t                           state;
  logic [tbd_pkg::OFFSET_W-1:0]     spike_offset;
  logic [tbd_pkg::HOLD_W-1:0]       hold_ms;
  logic [AW-1:0]                    write_slot;
  logic [CNT_W-1:0]                 fill_count;
  logic [tbd_pkg::TIME_W-1:0]       spike_start;
  logic                             spike_live;
  logic [tbd_pkg::SAMPLE_W-1:0]     s_reg;
  logic [tbd_pkg::TIME_W-1:0]       now_reg;

  logic                             accept;
  logic                             warm;
  logic                             mean_start;
  logic                             mean_done;
  logic [tbd_pkg::MEAN_W-1:0]       mean;
  logic                             rd_en;
  logic [AW-1:0]                    rd_addr;
  logic [tbd_pkg::SAMPLE_W-1:0]     rd_data;
  tbd_pkg::ring_wr_t                ring_wr;

  logic                             finish;
  logic [tbd_pkg::MEAN_W:0]         threshold;
  logic                             hit;
  logic [tbd_pkg::TIME_W-1:0]       elapsed;
  logic                             late;
  logic                             store;

  assign in_stall   = (state != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign accept     = in_valid && !in_stall;
  // fill_count saturates at WINDOW, so "not equal" is "still filling"
  assign warm       = (fill_count != CNT_W'(WINDOW));
  assign mean_start = accept && !warm;

  tbd_ring #(.WINDOW(WINDOW)) u_ring (
    .clk     (clk),
    .wr      (ring_wr),
    .wr_addr (write_slot),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tbd_mean #(.WINDOW(WINDOW)) u_mean (
    .clk     (clk),
    .rst     (rst),
    .start   (mean_start),
    .rd_data (rd_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .done    (mean_done),
    .mean    (mean)
  );

  // finish step: needs the output register free (or being emptied)
  assign finish    = (state == S_FINISH) && (!out_valid || !out_stall);
  // threshold formed one bit wider, never wraps
  assign threshold = {1'b0, mean} + {1'b0, spike_offset};
  assign hit       = ({1'b0, s_reg} > threshold);
  // elapsed time wraps modulo 2^32
  assign elapsed   = now_reg - spike_start;
  assign late      = (elapsed > {{(tbd_pkg::TIME_W - tbd_pkg::HOLD_W){1'b0}}, hold_ms});
  // quiet samples and warm-up samples go into the ring
  assign store     = warm || !hit;

  assign ring_wr = '{en: finish && store, data: s_reg};

  always_ff @(posedge clk) begin
    if (accept) begin
      s_reg   <= sample;
      now_reg <= now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      spike_offset <= tbd_pkg::SPIKE_OFFSET_RST;
      hold_ms      <= tbd_pkg::HOLD_MS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        tbd_pkg::REG_SPIKE_OFFSET: begin
          spike_offset <= cfg_data[tbd_pkg::OFFSET_W-1:0];
        end
        tbd_pkg::REG_HOLD_MS: begin
          hold_ms <= cfg_data[tbd_pkg::HOLD_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      write_slot  <= '0;
      fill_count  <= '0;
      spike_start <= '0;
      spike_live  <= 1'b0;
      out_valid   <= 1'b0;
      go          <= 1'b0;
      above       <= 1'b0;
      baseline    <= '0;
    end else begin
      // a finishing beat refills the register in the same cycle
      if (out_valid && !out_stall && !finish) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= warm ? S_FINISH : S_MEAN;
          end
        end
        S_MEAN: begin
          if (mean_done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (finish) begin
            state     <= S_IDLE;
            out_valid <= 1'b1;
            go        <= !warm && hit && spike_live && late;
            above     <= !warm && hit;
            baseline  <= warm ? '0 : mean;
            if (warm) begin
              fill_count <= fill_count + 1'b1;
            end
            if (store) begin
              write_slot <= (write_slot == AW'(WINDOW - 1)) ? '0 : write_slot + 1'b1;
            end
            if (!warm) begin
              if (!hit) begin
                spike_live <= 1'b0;
              end else if (!spike_live) begin
                spike_live  <= 1'b1;
                spike_start <= now_reg;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/tbd_ring.sv */
`default_nettype none

module tbd_ring #(
  parameter int WINDOW = tbd_pkg::WINDOW_DEF
) (
  input  wire logic                         clk,
  input  wire tbd_pkg::ring_wr_t            wr,
  input  wire logic [$clog2(WINDOW)-1:0]    wr_addr,
  input  wire logic                         rd_en,
  input  wire logic [$clog2(WINDOW)-1:0]    rd_addr,
  output logic      [tbd_pkg::SAMPLE_W-1:0] rd_data
);

  logic [tbd_pkg::SAMPLE_W-1:0] mem [WINDOW];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hdl/tbd_mean.sv */
`default_nettype none

// Serial ring sum on one shared adder, then one reciprocal multiply for the
// divide by WINDOW.
module tbd_mean #(
  parameter int WINDOW = tbd_pkg::WINDOW_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [tbd_pkg::SAMPLE_W-1:0] rd_data,
  output logic                              rd_en,
  output logic      [$clog2(WINDOW)-1:0]    rd_addr,
  output logic                              done,
  output logic      [tbd_pkg::MEAN_W-1:0]   mean
);

  localparam int AW      = $clog2(WINDOW);
  localparam int CNT_W   = $clog2(WINDOW + 1);
  localparam int SUM_W   = $clog2(WINDOW * ((2 ** tbd_pkg::SAMPLE_W) - 1) + 1);
  // floor(sum / WINDOW) = (sum * RECIP) >> SHIFT, exact for any SUM_W-bit sum
  localparam int SHIFT   = SUM_W + AW;
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((2 ** SHIFT) + WINDOW - 1) / WINDOW);

  typedef enum logic [2:0] {
    M_IDLE  = 3'b001,
    M_SUM   = 3'b010,
    M_SCALE = 3'b100
  } mean_state_t;

  mean_state_t                 state;
  logic [CNT_W-1:0]            issue_cnt;
  logic                        data_ok;
  logic [SUM_W-1:0]            acc;
  logic [SUM_W-1:0]            alu;
  logic [PROD_W-1:0]           prod;

  assign rd_en   = (state == M_SUM) && (issue_cnt != CNT_W'(WINDOW));
  assign rd_addr = issue_cnt[AW-1:0];

  // shared adder: the ring total never exceeds SUM_W bits
  assign alu  = acc + SUM_W'(rd_data);
  assign prod = {{RECIP_W{1'b0}}, acc} * {{SUM_W{1'b0}}, RECIP};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= M_IDLE;
      issue_cnt <= '0;
      data_ok   <= 1'b0;
      done      <= 1'b0;
    end else begin
      data_ok <= rd_en;
      done    <= (state == M_SCALE);
      case (state)
        M_IDLE: begin
          if (start) begin
            state     <= M_SUM;
            issue_cnt <= '0;
            acc       <= '0;
          end
        end
        M_SUM: begin
          if (rd_en) begin
            issue_cnt <= issue_cnt + 1'b1;
          end
          if (data_ok) begin
            acc <= alu;
          end
          if (data_ok && (issue_cnt == CNT_W'(WINDOW))) begin
            state <= M_SCALE;
          end
        end
        M_SCALE: begin
          mean  <= prod[SHIFT +: tbd_pkg::MEAN_W];
          state <= M_IDLE;
        end
        default: begin
          state <= M_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/tbd_checker.sv */
`default_nettype none
`include "tone_burst_detector_unit_defines.svh"

module tbd_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire logic [tbd_pkg::SAMPLE_W-1:0]   sample,
  input wire logic [tbd_pkg::TIME_W-1:0]     now_ms,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic                           go,
  input wire logic                           above,
  input wire logic [tbd_pkg::MEAN_W-1:0]     baseline,
  input wire logic                           cfg_valid,
  input wire logic                           cfg_ready,
  input wire logic [tbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input wire logic [tbd_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic unused_ok;
  assign unused_ok = ^{sample, now_ms, cfg_valid, cfg_ready, cfg_index, cfg_data};

  // go only ever comes with a sample above threshold
  `TBD_ASSERT_IMPLY(a_go_needs_above, clk, rst, out_valid && go, above)

  // one beat at a time: busy straight after an accepted beat
  `TBD_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)

  // held result stays put
  `TBD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(go) && $stable(above) && $stable(baseline))

  // ready and empty straight out of reset
  `TBD_ASSERT_IMPLY(a_idle_after_reset, clk, rst, $past(rst), !in_stall && !out_valid)

endmodule

bind tone_burst_detector_unit tbd_checker u_tbd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .sample    (sample),
  .now_ms    (now_ms),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .go        (go),
  .above     (above),
  .baseline  (baseline),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data)
);

`default_nettype wire

/* test/tone_burst_detector_unit_tb.sv */
`default_nettype none

module tone_burst_detector_unit_tb;

  import tbd_pkg::*;

  // receiver hold-off used to back the block up against its input
  localparam int HOLD_OFF_CYCLES = 400;
  // cycles without any beat before the run is declared hung
  localparam int IDLE_LIMIT      = 4000;
  // settle time once nothing is owed: worst-case latency plus margin
  localparam int TAIL_CYCLES     = WINDOW_DEF + 30;

  // Shadow of the detector: quiet ring, warm-up count, spike tracking and the
  // two levels. Each accepted sample beat yields exactly one owed verdict.
  class burst_scoreboard;
    typedef struct packed {
      logic              go;
      logic              above;
      logic [MEAN_W-1:0] base;
    } verdict_t;

    logic [OFFSET_W-1:0] offset;
    logic [HOLD_W-1:0]   hold;
    logic [SAMPLE_W-1:0] ring [WINDOW_DEF];
    int unsigned         slot;
    int unsigned         filled;
    logic [TIME_W-1:0]   spike_t0;
    bit                  in_spike;
    verdict_t            owed [$];
    int                  errors;

    function new();
      offset   = SPIKE_OFFSET_RST;
      hold     = HOLD_MS_RST;
      foreach (ring[k]) ring[k] = '0;
      slot     = 0;
      filled   = 0;
      spike_t0 = '0;
      in_spike = 1'b0;
      errors   = 0;
    endfunction

    function int mean_level();
      int sum;
      sum = 0;
      foreach (ring[k]) sum += int'(ring[k]);
      return sum / WINDOW_DEF;
    endfunction

    // full-width threshold, -1 while the ring is still filling
    function int threshold();
      if (filled < WINDOW_DEF) return -1;
      return mean_level() + int'(offset);
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function void keep_quiet(logic [SAMPLE_W-1:0] s);
      ring[slot] = s;
      slot = (slot == WINDOW_DEF - 1) ? 0 : slot + 1;
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] word);
      if (idx == REG_SPIKE_OFFSET) offset = word[OFFSET_W-1:0];
      else if (idx == REG_HOLD_MS) hold = word[HOLD_W-1:0];
    endfunction

    function void note_input(logic [SAMPLE_W-1:0] s, logic [TIME_W-1:0] stamp);
      verdict_t          v;
      logic [TIME_W-1:0] held;
      v = '0;
      if (filled < WINDOW_DEF) begin
        keep_quiet(s);
        filled++;
      end else begin
        v.base = MEAN_W'(mean_level());
        if (int'(s) > threshold()) begin
          v.above = 1'b1;
          if (!in_spike) begin
            in_spike = 1'b1;
            spike_t0 = stamp;
          end else begin
            held = stamp - spike_t0;
            v.go = (held > TIME_W'(hold));
          end
        end else begin
          in_spike = 1'b0;
          keep_quiet(s);
        end
      end
      owed.push_back(v);
    endfunction

    task report(string what);
      $display("MISMATCH @%0t: %s", $time, what);
      errors++;
    endtask

    task check_result(logic go_bit, logic above_bit, logic [MEAN_W-1:0] base);
      verdict_t v;
      if (owed.size() == 0) begin
        report($sformatf("unexpected result go=%0b above=%0b baseline=%0d",
                         go_bit, above_bit, base));
        return;
      end
      v = owed.pop_front();
      if (go_bit !== v.go)
        report($sformatf("go %0b, expected %0b", go_bit, v.go));
      if (above_bit !== v.above)
        report($sformatf("above %0b, expected %0b", above_bit, v.above));
      if (base !== v.base)
        report($sformatf("baseline %0d, expected %0d", base, v.base));
    endtask
  endclass

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [SAMPLE_W-1:0]   sample    = '0;
  logic [TIME_W-1:0]     now_ms    = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  go;
  logic                  above;
  logic [MEAN_W-1:0]     baseline;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_SPIKE_OFFSET;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  burst_scoreboard sb;

  // sender pacing: burst length left, and a flag that switches gaps off
  int   burst_left   = 0;
  bit   steady       = 1'b0;
  // raised by the stimulus, cleared by the receiver once its hold-off is done
  bit   hold_off_req = 1'b0;
  int   idle_cycles  = 0;
  // running millisecond clock for well-formed sequences
  logic [TIME_W-1:0] tick_ms = '0;

  always #5 clk = ~clk;

  tone_burst_detector_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .now_ms    (now_ms),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .go        (go),
    .above     (above),
    .baseline  (baseline),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // -------------------------------------------------------------------------
  // Sample pickers. Both read the shadow state as it stands after the last
  // accepted beat, so a quiet pick really is quiet and a spike pick really
  // clears the threshold.
  // -------------------------------------------------------------------------

  // at or below threshold, mostly close to the baseline so it stays put;
  // now and then exactly on the threshold
  function automatic logic [SAMPLE_W-1:0] quiet_level();
    int t;
    int b;
    t = sb.threshold();
    if (t < 0) return SAMPLE_W'($urandom_range(0, 1023));
    b = sb.mean_level();
    if (t > 1023) t = 1023;
    if ($urandom_range(0, 7) == 0) return SAMPLE_W'(t);
    return SAMPLE_W'($urandom_range((b > 40) ? b - 40 : 0, t));
  endfunction

  // strictly above threshold; falls back to quiet when the threshold sits
  // at or past full scale and no spike can exist
  function automatic logic [SAMPLE_W-1:0] spike_level();
    int t;
    t = sb.threshold();
    if (t < 0 || t >= 1023) return quiet_level();
    if ($urandom_range(0, 7) == 0) return SAMPLE_W'(t + 1);
    return SAMPLE_W'($urandom_range(t + 1, 1023));
  endfunction

  // -------------------------------------------------------------------------
  // Drivers
  // -------------------------------------------------------------------------

  // offer one sample beat, hold it until taken, then maybe open a gap;
  // valid stays high between beats of one burst
  task automatic send_beat(input logic [SAMPLE_W-1:0] s, input logic [TIME_W-1:0] stamp);
    in_valid <= 1'b1;
    sample   <= s;
    now_ms   <= stamp;
    do @(posedge clk); while (in_stall);
    sb.note_input(s, stamp);
    if (!steady) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  // stop offering and wait until every owed result has been taken
  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // write both registers back to back; valid stays high across the two beats
  task automatic set_levels(input logic [CFG_DATA_W-1:0] offset_word,
                            input logic [CFG_DATA_W-1:0] hold_word);
    cfg_valid <= 1'b1;
    cfg_index <= REG_SPIKE_OFFSET;
    cfg_data  <= offset_word;
    do @(posedge clk); while (!cfg_ready);
    sb.note_config(REG_SPIKE_OFFSET, offset_word);
    cfg_index <= REG_HOLD_MS;
    cfg_data  <= hold_word;
    do @(posedge clk); while (!cfg_ready);
    sb.note_config(REG_HOLD_MS, hold_word);
    cfg_valid <= 1'b0;
  endtask

  // -------------------------------------------------------------------------
  // Directed part: warm-up ending on a full-scale value, the threshold edge,
  // a spike opening at time zero, the hold boundary, a spike across the
  // 32-bit wrap, an out-of-range threshold, zero offset and zero hold,
  // and the longest hold.
  // -------------------------------------------------------------------------
  task automatic directed_cases();
    logic [SAMPLE_W-1:0] s;
    logic [TIME_W-1:0]   stamp;
    logic [TIME_W-1:0]   t0;
    int                  t;
    // warm-up: last sample is full scale and must not be compared
    for (int k = 0; k < WINDOW_DEF; k++) begin
      stamp = TIME_W'(k * 50);
      if (k == 0) begin
        s = '0;
      end else if (k == WINDOW_DEF - 1) begin
        s = '1;
      end else if (k == 1) begin
        s = 10'h2AA;
        stamp = '1;
      end else if (k == 2) begin
        s = 10'h155;
        stamp = 32'hAAAA_AAAA;
      end else begin
        s = 10'd300;
        stamp = 32'h5555_5555;
      end
      send_beat(s, stamp);
    end

    // exactly on the threshold counts as quiet
    t = sb.threshold();
    send_beat(SAMPLE_W'(t), 32'd40);
    // one above opens a spike; a zero timestamp is a valid start
    t = sb.threshold();
    send_beat(SAMPLE_W'(t + 1), 32'd0);
    send_beat(spike_level(), 32'd1000);  // elapsed equals hold: no go
    send_beat(spike_level(), 32'd1001);  // one past hold: go
    send_beat(SAMPLE_W'(sb.mean_level()), 32'd2000);  // spike ends

    // spike running across the wrap of the ms counter
    send_beat(spike_level(), 32'hFFFF_FF00);
    send_beat(spike_level(), 32'h0000_02E8);
    send_beat(spike_level(), 32'h0000_02E9);
    send_beat(quiet_level(), 32'h0000_0400);

    // offset at full scale (upper data bits set too): threshold past 1023,
    // a full-scale sample stays quiet
    drain();
    set_levels(16'hFFFF, 16'h0000);
    send_beat(10'h3FF, 32'h0000_1000);

    // zero offset, zero hold: go as soon as any time has passed
    drain();
    set_levels(16'hFC00, 16'h0000);
    t0 = 32'h8000_0000;
    send_beat(SAMPLE_W'(sb.mean_level() + 1), t0);
    send_beat(spike_level(), t0);
    send_beat(spike_level(), t0 + 32'd1);
    send_beat(SAMPLE_W'(sb.mean_level()), t0 + 32'd2);

    // longest hold
    drain();
    set_levels(16'h0000, 16'hFFFF);
    send_beat(SAMPLE_W'(sb.mean_level() + 1), t0 + 32'd10);
    send_beat(spike_level(), t0 + 32'd10 + 32'd65535);
    send_beat(spike_level(), t0 + 32'd10 + 32'd65536);
    send_beat(SAMPLE_W'(sb.mean_level()), t0 + 32'd70000);
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin : stimulus
    logic [OFFSET_W-1:0]   off;
    logic [HOLD_W-1:0]     hold_word;
    logic [CFG_DATA_W-1:0] word;
    int                    step_max;
    int                    sent;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_cases();

    // Random phases, each under its own levels. Most traffic is quiet runs
    // followed by spike runs on a steadily advancing clock, so holds are
    // actually crossed; a quarter is noise with random time and level.
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: begin
          off       = SPIKE_OFFSET_RST;
          hold_word = HOLD_MS_RST;
        end
        2: begin
          off       = '1;
          hold_word = HOLD_W'($urandom);
        end
        3: begin
          off       = '0;
          hold_word = '1;
        end
        default: begin
          off       = OFFSET_W'($urandom_range(0, 200));
          hold_word = HOLD_W'($urandom_range(0, 3000));
        end
      endcase
      word = CFG_DATA_W'($urandom);
      word[OFFSET_W-1:0] = off;
      set_levels(word, hold_word);

      step_max = int'(hold_word) / 4 + 20;
      // each phase starts just short of the wrap with even odds
      if ($urandom_range(0, 1) == 1)
        tick_ms = 32'hFFFF_FFFF - TIME_W'($urandom_range(0, 4 * step_max));

      // one phase without sender gaps; another backs the block up while
      // the receiver holds off
      steady = (ph == 4);
      if (ph == 1) begin
        hold_off_req = 1'b1;
        steady       = 1'b1;
      end

      sent = 0;
      while (sent < 88) begin
        if (ph == 1 && sent >= 30) steady = 1'b0;
        if ($urandom_range(0, 3) == 0) begin
          send_beat(SAMPLE_W'($urandom), TIME_W'($urandom));
          sent++;
        end else begin
          repeat ($urandom_range(1, 5)) begin
            tick_ms += TIME_W'($urandom_range(1, step_max));
            send_beat(quiet_level(), tick_ms);
            sent++;
          end
          repeat ($urandom_range(1, 14)) begin
            tick_ms += TIME_W'($urandom_range(1, step_max));
            send_beat(spike_level(), tick_ms);
            sent++;
          end
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // -------------------------------------------------------------------------
  // Receiver: stretches of its own stall pattern, from none to heavy; the
  // long hold-off runs here so it is counted independently of the sender
  // -------------------------------------------------------------------------
  initial begin : receiver
    int span;
    int mode;
    forever begin
      mode = $urandom_range(0, 5);
      span = $urandom_range(10, 150);
      repeat (span) begin
        @(posedge clk);
        if (hold_off_req) begin
          out_stall <= 1'b1;
          repeat (HOLD_OFF_CYCLES) @(posedge clk);
          hold_off_req = 1'b0;
        end
        case (mode)
          0, 1:    out_stall <= 1'b0;
          2:       out_stall <= ($urandom_range(0, 3) == 0);
          3:       out_stall <= 1'($urandom_range(0, 1));
          4:       out_stall <= ($urandom_range(0, 7) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // result beats are checked on the edge that takes them
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(go, above, baseline);
  end

  // hang guard: any beat on any channel restarts the count
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

`default_nettype wire
